// ===== design/fpfir_pkg.sv =====
// Shared types and constants for the fixed-point FIR filter core.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package fpfir_pkg;

    // Field widths
    localparam int DATA_W     = 32;  // Q1.31 samples, Q4.28 coefficients
    localparam int ACC_W      = 64;  // wrapping Q5.59 accumulator
    localparam int TAP_IDX_W  = 6;   // width of the coefficient index field
    localparam int COEF_SHIFT = 28;  // Q5.59 back to Q1.31

    // Operation codes on the input channel
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clr;    // write zero to both tables at the tap index
        logic push;   // store a new sample, restart the sum
        logic load;   // write one coefficient
        logic issue;  // read one tap pair into the MAC pipeline
        logic emit;   // load the saturated sum into the output register
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic pipe_busy;  // reads or products still in flight
        logic out_free;   // output register can take a new word this cycle
    } status_t;

endpackage

`default_nettype wire

// ===== design/fixed_point_fir_filter_core.sv =====
// Top level of the fixed-point FIR filter core: controller plus datapath.
// Depends on fpfir_pkg, fpfir_ctrl, fpfir_dp (and fpfir_ram through the datapath).
//
//   Channel | Prefix | Carries
//   --------+--------+--------------------------------------------------------
//   input   | s_     | operation, sample_in, coef_index, coef_value (one word)
//   result  | m_     | sample_out, one word per sample push, none for a load
//
// After reset a clearing pass zeroes both tables entry by entry; s_ready is low
// throughout. A coefficient load is written at intake. A sample push runs through
// the intake, TAPS reads through the single shared multiply-accumulate, a drain
// of the read and product registers into the sum, then the hand-off. A waiting
// result does not block intake; a new sum waits for the output register only at
// its own hand-off.
`default_nettype none

module fixed_point_fir_filter_core #(
    parameter int TAPS = 64
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic                                   s_operation,
    input  wire logic signed [fpfir_pkg::DATA_W-1:0]    s_sample_in,
    input  wire logic        [fpfir_pkg::TAP_IDX_W-1:0] s_coef_index,
    input  wire logic signed [fpfir_pkg::DATA_W-1:0]    s_coef_value,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed      [fpfir_pkg::DATA_W-1:0]    m_sample_out
);

    localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;

    fpfir_pkg::cmd_t    cmd;
    fpfir_pkg::status_t status;
    logic [AW-1:0]      tap_idx;

    fpfir_ctrl #(.TAPS(TAPS), .AW(AW)) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_coef_index (s_coef_index),
        .status       (status),
        .cmd          (cmd),
        .tap_idx      (tap_idx)
    );

    fpfir_dp #(.TAPS(TAPS), .AW(AW)) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .tap_idx      (tap_idx),
        .s_sample_in  (s_sample_in),
        .s_coef_index (s_coef_index),
        .s_coef_value (s_coef_value),
        .status       (status),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out)
    );

endmodule

`default_nettype wire

// ===== design/fpfir_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module fpfir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/fpfir_ctrl.sv =====
// Controller state machine: clearing pass, item intake, tap sequencing, result hand-off.
// Depends on fpfir_pkg.
`default_nettype none

module fpfir_ctrl #(
    parameter int TAPS = 64,
    parameter int AW   = (TAPS > 1) ? $clog2(TAPS) : 1
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_operation,
    input  wire logic [fpfir_pkg::TAP_IDX_W-1:0] s_coef_index,
    input  wire fpfir_pkg::status_t             status,
    output fpfir_pkg::cmd_t                     cmd,
    output logic      [AW-1:0]                  tap_idx
);

    localparam logic [AW-1:0] LAST_TAP = AW'(TAPS - 1);
    localparam logic [10:0]   TAPS_W   = 11'(TAPS);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_RUN   = 5'b00100,
        S_DRAIN = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   cnt_reg, cnt_next;
    logic            accept;
    logic            coef_ok;

    assign accept  = s_valid && s_ready;
    assign coef_ok = {5'b0, s_coef_index} < TAPS_W;
    assign s_ready = (state_reg == S_IDLE);
    assign tap_idx = cnt_reg;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr = 1'b1;
                if (cnt_reg == LAST_TAP) begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (s_operation == fpfir_pkg::OP_PUSH) begin
                        cmd.push   = 1'b1;
                        cnt_next   = '0;
                        state_next = S_RUN;
                    end else begin
                        cmd.load = coef_ok;
                    end
                end
            end
            S_RUN: begin
                cmd.issue = 1'b1;
                if (cnt_reg == LAST_TAP) begin
                    cnt_next   = '0;
                    state_next = S_DRAIN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
                cnt_next   = '0;
            end
        endcase
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    // Intake only with the MAC pipeline empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !status.pipe_busy)
        else $error("fpfir_ctrl: word accepted while MAC pipeline busy");

    // A new sample starts the tap sweep at tap zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |=> (cmd.issue && cnt_reg == '0))
        else $error("fpfir_ctrl: tap sweep did not start at tap zero");

    // Reset always leads into the clearing pass
    assert property (@(posedge aclk)
        !aresetn |=> (state_reg == S_CLEAR && cnt_reg == '0))
        else $error("fpfir_ctrl: reset did not start the clearing pass");
`endif

endmodule

`default_nettype wire

// ===== design/fpfir_dp.sv =====
// Datapath: history and coefficient RAMs, shared MAC pipeline, saturation, output register.
// Depends on fpfir_pkg and fpfir_ram.
`default_nettype none

module fpfir_dp #(
    parameter int TAPS = 64,
    parameter int AW   = (TAPS > 1) ? $clog2(TAPS) : 1
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire fpfir_pkg::cmd_t                       cmd,
    input  wire logic        [AW-1:0]                  tap_idx,
    input  wire logic signed [fpfir_pkg::DATA_W-1:0]   s_sample_in,
    input  wire logic        [fpfir_pkg::TAP_IDX_W-1:0] s_coef_index,
    input  wire logic signed [fpfir_pkg::DATA_W-1:0]   s_coef_value,
    output fpfir_pkg::status_t                         status,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic signed      [fpfir_pkg::DATA_W-1:0]   m_sample_out
);

    localparam int            DW       = fpfir_pkg::DATA_W;
    localparam int            CW       = fpfir_pkg::ACC_W;
    localparam int            SH       = fpfir_pkg::COEF_SHIFT;
    localparam logic [AW-1:0] LAST_TAP = AW'(TAPS - 1);

    logic [AW-1:0]        wp_reg, wp_next, wp_inc;
    logic [AW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic                 rd_vld_reg, prod_vld_reg;
    logic                 out_vld_reg, out_vld_next;
    logic signed [CW-1:0] prod_reg, prod_next;
    logic [CW-1:0]        acc_reg, acc_next;
    logic [DW-1:0]        out_reg;
    logic [DW-1:0]        sat_val;

    logic                 hist_we, coef_we;
    logic [AW-1:0]        hist_waddr, coef_waddr;
    logic [DW-1:0]        hist_wdata, coef_wdata;
    logic [DW-1:0]        hist_rd, coef_rd;

    // Circular history: newest word at wp, tap k at wp - k
    assign wp_inc  = (wp_reg == LAST_TAP) ? '0 : wp_reg + 1'b1;
    assign wp_next = cmd.push ? wp_inc : wp_reg;

    always_comb begin
        rd_ptr_next = rd_ptr_reg;
        if (cmd.push) begin
            rd_ptr_next = wp_inc;
        end else if (cmd.issue) begin
            rd_ptr_next = (rd_ptr_reg == '0) ? LAST_TAP : rd_ptr_reg - 1'b1;
        end
    end

    // RAM write ports: clearing pass or new item
    assign hist_we    = cmd.clr || cmd.push;
    assign hist_waddr = cmd.clr ? tap_idx : wp_inc;
    assign hist_wdata = cmd.clr ? '0 : s_sample_in;
    assign coef_we    = cmd.clr || cmd.load;
    assign coef_waddr = cmd.clr ? tap_idx : AW'(s_coef_index);
    assign coef_wdata = cmd.clr ? '0 : s_coef_value;

    fpfir_ram #(.WIDTH(DW), .DEPTH(TAPS), .AW(AW)) u_hist_ram (
        .aclk  (aclk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (rd_ptr_reg),
        .rdata (hist_rd)
    );

    fpfir_ram #(.WIDTH(DW), .DEPTH(TAPS), .AW(AW)) u_coef_ram (
        .aclk  (aclk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coef_wdata),
        .raddr (tap_idx),
        .rdata (coef_rd)
    );

    // One 32x32 signed product per cycle, then a wrapping 64-bit add
    assign prod_next = $signed(hist_rd) * $signed(coef_rd);
    assign acc_next  = cmd.push ? '0 :
                       (prod_vld_reg ? acc_reg + CW'(prod_reg) : acc_reg);

    // Arithmetic shift by 28 and saturation to signed 32 bits
    always_comb begin
        if (acc_reg[CW-1:SH+DW-1] == {(CW-SH-DW+1){acc_reg[SH+DW-1]}}) begin
            sat_val = acc_reg[SH+DW-1:SH];
        end else if (acc_reg[CW-1]) begin
            sat_val = {1'b1, {(DW-1){1'b0}}};
        end else begin
            sat_val = {1'b0, {(DW-1){1'b1}}};
        end
    end

    // Output word register
    always_comb begin
        out_vld_next = out_vld_reg;
        if (cmd.emit) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg       <= '0;
            rd_ptr_reg   <= '0;
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            wp_reg       <= wp_next;
            rd_ptr_reg   <= rd_ptr_next;
            rd_vld_reg   <= cmd.issue;
            prod_vld_reg <= rd_vld_reg;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (cmd.emit) begin
            out_reg <= sat_val;
        end
    end

    assign status.pipe_busy = rd_vld_reg || prod_vld_reg;
    assign status.out_free  = !out_vld_reg || m_ready;
    assign m_valid          = out_vld_reg;
    assign m_sample_out     = out_reg;

endmodule

`default_nettype wire

// ===== verif/fir_output_checker.sv =====
// Output checker for the fixed-point FIR filter core: watches both channels,
// predicts each filtered sample and compares it. Depends on fpfir_pkg.
`default_nettype none

module fir_output_checker #(
    parameter int TAPS = 64
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_valid,
    input  wire logic                                   s_ready,
    input  wire logic                                   s_operation,
    input  wire logic signed [fpfir_pkg::DATA_W-1:0]    s_sample_in,
    input  wire logic        [fpfir_pkg::TAP_IDX_W-1:0] s_coef_index,
    input  wire logic signed [fpfir_pkg::DATA_W-1:0]    s_coef_value,
    input  wire logic                                   m_valid,
    input  wire logic                                   m_ready,
    input  wire logic signed [fpfir_pkg::DATA_W-1:0]    m_sample_out,
    output int                                          fail_count,
    output int                                          pending_count
);

    localparam int DW = fpfir_pkg::DATA_W;
    localparam int CW = fpfir_pkg::ACC_W;

    localparam logic signed [CW-1:0] OUT_MAX = 64'sd2147483647;
    localparam logic signed [CW-1:0] OUT_MIN = -64'sd2147483648;

    // Shadow copies of the sample history (newest at tap 0) and the taps
    logic signed [DW-1:0] sample_hist [TAPS];
    logic signed [DW-1:0] tap_coefs   [TAPS];
    logic        [DW-1:0] filtered_q  [$];
    logic        [DW-1:0] want_word;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // Shift in one sample and work out the saturated Q1.31 output
    function automatic logic [DW-1:0] filter_push(input logic signed [DW-1:0] smp);
        logic signed [CW-1:0] acc;
        logic signed [CW-1:0] prod;
        logic signed [CW-1:0] shifted;
        acc = '0;
        for (int k = TAPS - 1; k > 0; k--)
            sample_hist[k] = sample_hist[k-1];
        sample_hist[0] = smp;
        for (int k = 0; k < TAPS; k++) begin
            prod = sample_hist[k] * tap_coefs[k];
            acc  = acc + prod;  // wraps modulo 2^64
        end
        shifted = acc >>> fpfir_pkg::COEF_SHIFT;
        if (shifted > OUT_MAX)
            shifted = OUT_MAX;
        else if (shifted < OUT_MIN)
            shifted = OUT_MIN;
        return shifted[DW-1:0];
    endfunction

    // Track accepted words on both channels at each rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < TAPS; k++) begin
                sample_hist[k] = '0;
                tap_coefs[k]   = '0;
            end
            filtered_q.delete();
            fail_count    = 0;
            pending_count = 0;
        end else begin
            if (s_valid && s_ready) begin
                if (s_operation == fpfir_pkg::OP_LOAD) begin
                    // loads past the end of the table are dropped
                    if (int'(s_coef_index) < TAPS)
                        tap_coefs[s_coef_index] = s_coef_value;
                end else begin
                    filtered_q.push_back(filter_push(s_sample_in));
                end
            end
            if (m_valid && m_ready) begin
                if (filtered_q.size() == 0) begin
                    report_mismatch($sformatf("output word %h with none expected",
                                              m_sample_out));
                end else begin
                    want_word = filtered_q.pop_front();
                    if (m_sample_out !== want_word)
                        report_mismatch($sformatf("sample_out %h, expected %h",
                                                  m_sample_out, want_word));
                end
            end
            pending_count = filtered_q.size();
        end
    end

endmodule

`default_nettype wire

// ===== verif/fixed_point_fir_filter_core_tb.sv =====
// Testbench top for the fixed-point FIR filter core: clock, reset, stimulus
// and verdict. Depends on fpfir_pkg, the core and fir_output_checker.
`default_nettype none

module fixed_point_fir_filter_core_tb;

    localparam int          TAPS           = 64;
    localparam int          DW             = fpfir_pkg::DATA_W;
    localparam int          IW             = fpfir_pkg::TAP_IDX_W;
    localparam int          RANDOM_WORDS   = 1330;
    localparam int unsigned TIMEOUT_CYCLES = 900_000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_operation;
    logic signed [DW-1:0] s_sample_in;
    logic [IW-1:0]        s_coef_index;
    logic signed [DW-1:0] s_coef_value;
    logic                 m_valid;
    logic                 m_ready;
    logic signed [DW-1:0] m_sample_out;

    int fail_count;
    int pending_count;
    int send_gap_pct;
    int recv_stall_pct;

    fixed_point_fir_filter_core #(.TAPS(TAPS)) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_sample_in  (s_sample_in),
        .s_coef_index (s_coef_index),
        .s_coef_value (s_coef_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out)
    );

    fir_output_checker #(.TAPS(TAPS)) checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_sample_in   (s_sample_in),
        .s_coef_index  (s_coef_index),
        .s_coef_value  (s_coef_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sample_out  (m_sample_out),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always #1 aclk = ~aclk;

    // Receiver back-pressure, redrawn every falling edge
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Present one word after an optional idle gap, hold until accepted
    task automatic send_word(input logic op, input logic [DW-1:0] smp,
                             input logic [IW-1:0] idx,
                             input logic [DW-1:0] cv);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_gap_pct)
            gap++;
        if (send_gap_pct != 0 && $urandom_range(0, 7) == 0)
            gap += $urandom_range(1, TAPS + 8);  // lands at varied points of a sum
        repeat (gap) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid      = 1'b1;
        s_operation  = op;
        s_sample_in  = smp;
        s_coef_index = idx;
        s_coef_value = cv;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Hold off until every outstanding output word has been taken
    task automatic drain_outputs();
        s_valid = 1'b0;
        while (pending_count != 0)
            @(negedge aclk);
    endtask

    // Safety net against a hung run
    initial begin
        #(2 * TIMEOUT_CYCLES);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        logic [DW-1:0] rnd;
        logic [DW-1:0] cv;
        int            phase_len;
        aclk           = 1'b0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_operation    = fpfir_pkg::OP_PUSH;
        s_sample_in    = '0;
        s_coef_index   = '0;
        s_coef_value   = '0;
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        phase_len      = RANDOM_WORDS / 4;

        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: zero table, unity tap, saturation both ways, wrap-around
        send_word(fpfir_pkg::OP_PUSH, 32'h7FFF_FFFF, 6'd5,  32'h7FFF_FFFF);
        send_word(fpfir_pkg::OP_LOAD, 32'h8000_0000, 6'd0,  32'h1000_0000);
        send_word(fpfir_pkg::OP_PUSH, 32'h7FFF_FFFF, 6'd63, 32'h8000_0000);
        send_word(fpfir_pkg::OP_PUSH, 32'h8000_0000, 6'd0,  32'h0000_0000);
        send_word(fpfir_pkg::OP_PUSH, 32'h0000_0001, 6'd21, 32'hFFFF_FFFF);
        send_word(fpfir_pkg::OP_LOAD, 32'hFFFF_FFFF, 6'd0,  32'h7FFF_FFFF);
        send_word(fpfir_pkg::OP_PUSH, 32'h7FFF_FFFF, 6'd0,  32'h0000_0000);
        send_word(fpfir_pkg::OP_PUSH, 32'h8000_0000, 6'd0,  32'h0000_0000);
        send_word(fpfir_pkg::OP_PUSH, 32'hFFFF_FFFF, 6'd0,  32'h0000_0000);
        send_word(fpfir_pkg::OP_LOAD, 32'h0000_0000, 6'd0,  32'h8000_0000);
        send_word(fpfir_pkg::OP_LOAD, 32'h0000_0000, 6'd1,  32'h8000_0000);
        send_word(fpfir_pkg::OP_LOAD, 32'h0000_0000, 6'd2,  32'h8000_0000);
        send_word(fpfir_pkg::OP_PUSH, 32'h8000_0000, 6'd42, 32'h5555_5555);
        send_word(fpfir_pkg::OP_PUSH, 32'h8000_0000, 6'd42, 32'hAAAA_AAAA);
        send_word(fpfir_pkg::OP_PUSH, 32'h8000_0000, 6'd42, 32'h5555_5555);
        send_word(fpfir_pkg::OP_LOAD, 32'h1234_5678, 6'd63, 32'h7FFF_FFFF);
        send_word(fpfir_pkg::OP_LOAD, 32'h1234_5678, 6'd63, 32'h8000_0000);
        send_word(fpfir_pkg::OP_PUSH, 32'h0000_0000, 6'd0,  32'h0000_0000);
        send_word(fpfir_pkg::OP_LOAD, 32'h0000_0000, 6'd0,  32'h0000_0000);
        send_word(fpfir_pkg::OP_LOAD, 32'h0000_0000, 6'd1,  32'h0000_0000);
        send_word(fpfir_pkg::OP_LOAD, 32'h0000_0000, 6'd2,  32'h0000_0000);
        send_word(fpfir_pkg::OP_PUSH, 32'h4000_0000, 6'd0,  32'h0000_0000);

        // Random: mostly modest taps so sums stay in range, some full-scale
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i % phase_len == 0) begin
                drain_outputs();
                case (i / phase_len)
                    0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                    1: begin send_gap_pct = 62; recv_stall_pct = 0;  end
                    2: begin send_gap_pct = 0;  recv_stall_pct = 62; end
                    default: begin send_gap_pct = 13; recv_stall_pct = 13; end
                endcase
            end else if ($urandom_range(0, 49) == 0) begin
                drain_outputs();
            end
            rnd = $urandom;
            cv  = $urandom;
            if ($urandom_range(0, 4) != 0)
                cv = {{8{cv[23]}}, cv[23:0]};
            if ($urandom_range(0, 99) < 15)
                send_word(fpfir_pkg::OP_LOAD, rnd, IW'($urandom), cv);
            else
                send_word(fpfir_pkg::OP_PUSH, rnd, IW'($urandom), $urandom);
        end
        s_valid = 1'b0;

        // Let the last sums come out, then watch for strays
        while (pending_count != 0)
            @(negedge aclk);
        repeat (TAPS + 16) @(negedge aclk);

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
